// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL, included by rtcp_report_interval.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rri_pkg.sv =====
package rri_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int RAND_BITS_DEF   = 15;

    localparam int BW_W   = 30;   // session bandwidth register
    localparam int MIN_W  = 26;   // minimum interval register
    localparam int SIZE_W = 16;   // report size and running average
    localparam int OUT_W  = 40;   // interval result
    localparam int TW     = 42;   // capped interval, holds 2^41
    localparam int K_W    = 22;   // scale factor, holds 4e6
    localparam int DW     = BW_W + 2;  // divisor, holds 3 * bandwidth

    localparam logic [SIZE_W-1:0] INIT_AVG  = SIZE_W'(128);
    localparam logic [K_W-1:0]    K_ONE     = K_W'(1000000);
    localparam logic [K_W-1:0]    K_FOUR    = K_W'(4000000);
    localparam logic [TW-1:0]     T_CAP     = TW'(1) << (TW - 1);
    localparam logic [BW_W-1:0]   BW_RESET  = BW_W'(1000);
    localparam logic [MIN_W-1:0]  MIN_RESET = MIN_W'(5000000);

    // Configuration register indexes
    localparam logic CFG_SESSION_BW   = 1'b0;
    localparam logic CFG_MIN_INTERVAL = 1'b1;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

endpackage

// ===== hw/rtl/rri_alu.sv =====
module rri_alu #(
    parameter int W = 64
) (
    input  logic [W-1:0]     i_a,
    input  logic [W-1:0]     i_b,
    input  rri_pkg::t_alu_op i_op,
    output logic [W-1:0]     o_sum
);

    always_comb begin
        unique case (i_op)
            rri_pkg::ALU_ADD: o_sum = i_a + i_b;
            rri_pkg::ALU_SUB: o_sum = i_a - i_b;
            default:          o_sum = i_a + i_b;
        endcase
    end

endmodule

// ===== hw/rtl/rtcp_report_interval.sv =====
// RTCP report interval calculator.
// Slave stream (i_s_*): one request per item; tdata carries the member and
// sender counts, the we-sent flag, the last report size and the dither sample;
// tuser carries the first-call flag. Master stream (o_m_*): one result per
// request with the interval in microseconds and the updated average size.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 session bandwidth, 1 minimum interval); write only while the block is idle.
// The work runs on one shared adder, one bit a cycle, in loops: report average
// times count (16 steps), times the microsecond scale (22 steps) and
// restoring division by the bandwidth (38 + COUNT_WIDTH steps); then come a
// clamp step, the dither multiply (RAND_BITS + 1 steps), also on the adder,
// and the load of the output register.
// o_s_tready is high only between requests, so one request is in flight.
// A finished result waits in the output register; a new request is taken
// meanwhile, and its result holds in the last step until the register frees.
// Reset (synchronous, active low) restores bandwidth 1000, minimum interval
// 5000000 us, average size 128, and drops any pending request or result.
`include "assert_macros.svh"

module rtcp_report_interval #(
    parameter int COUNT_WIDTH = rri_pkg::COUNT_WIDTH_DEF,
    parameter int RAND_BITS   = rri_pkg::RAND_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // Configuration write port
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_index,
    input  logic [rri_pkg::BW_W-1:0] i_cfg_data,
    // Request stream
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // member_count, sender_count, we_sent, last_report_size, random_value, zero pad
    input  logic [(((2*COUNT_WIDTH + 17 + RAND_BITS) + 7) / 8) * 8 - 1:0] i_s_tdata,
    // first_call
    input  logic [0:0] i_s_tuser,
    // Result stream
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // interval_us, average_size
    output logic [((rri_pkg::OUT_W + rri_pkg::SIZE_W + 7) / 8) * 8 - 1:0] o_m_tdata
);

    localparam int CW    = COUNT_WIDTH;
    localparam int RB    = RAND_BITS;
    localparam int SW    = rri_pkg::SIZE_W;
    localparam int TW    = rri_pkg::TW;
    localparam int DW    = rri_pkg::DW;
    localparam int KW    = rri_pkg::K_W;
    localparam int OW    = rri_pkg::OUT_W;
    localparam int MW    = rri_pkg::MIN_W;
    localparam int QW    = SW + CW;           // avg * n
    localparam int PW    = QW + KW;           // avg * n * k, then quotient
    localparam int DTW   = TW + RB + 1;       // dither product
    localparam int AW    = (PW > DTW) ? PW : DTW;
    localparam int MPA   = (KW > SW) ? KW : SW;
    localparam int MPW   = (MPA > RB + 1) ? MPA : RB + 1;
    localparam int CNTW  = $clog2(AW + 1);
    localparam int ODW   = ((OW + SW + 7) / 8) * 8;

    localparam logic [RB:0] RAND_HALF = (RB + 1)'(1) << (RB - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MULQ,
        S_MULK,
        S_DIV,
        S_CLAMP,
        S_DITH,
        S_FIN
    } t_state;

    t_state             r_state;
    logic [CNTW-1:0]    r_cnt;
    logic [AW-1:0]      r_acc;
    logic [AW-1:0]      r_mcand;
    logic [MPW-1:0]     r_mplier;
    logic [PW-1:0]      r_p;
    logic [DW-1:0]      r_rem;
    logic [DW-1:0]      r_div;
    logic               r_k4;
    logic [MW-1:0]      r_min_t;
    logic [RB:0]        r_m;
    logic [SW-1:0]      r_avg;
    logic [rri_pkg::BW_W-1:0] r_bw;
    logic [MW-1:0]      r_min_cfg;
    logic               r_o_valid;
    logic [OW-1:0]      r_o_interval;
    logic [SW-1:0]      r_o_avg;

    // Request fields
    logic [CW-1:0] in_members;
    logic [CW-1:0] in_senders;
    logic          in_we_sent;
    logic [SW-1:0] in_size;
    logic [RB-1:0] in_rand;
    logic          in_first;

    assign in_members = i_s_tdata[CW-1:0];
    assign in_senders = i_s_tdata[2*CW-1:CW];
    assign in_we_sent = i_s_tdata[2*CW];
    assign in_size    = i_s_tdata[2*CW+SW:2*CW+1];
    assign in_rand    = i_s_tdata[2*CW+SW+RB:2*CW+SW+1];
    assign in_first   = i_s_tuser[0];

    // Request decode: average update, bandwidth share and count
    logic [SW-1:0] avg_base;
    logic [SW-1:0] avg_new;
    logic          few_senders;
    logic [CW-1:0] n_sel;
    logic [DW-1:0] div_sel;

    always_comb begin
        avg_base = in_first ? rri_pkg::INIT_AVG : r_avg;
        if (in_size >= avg_base) begin
            avg_new = avg_base + ((in_size - avg_base) >> 4);
        end else begin
            avg_new = avg_base - ((avg_base - in_size) >> 4);
        end
        few_senders = (in_senders != '0) &&
                      (({2'b00, in_senders} << 2) < {2'b00, in_members});
        if (few_senders && in_we_sent) begin
            n_sel   = in_senders;
            div_sel = DW'(r_bw);
        end else if (few_senders) begin
            n_sel   = in_members - in_senders;
            div_sel = DW'(r_bw) + (DW'(r_bw) << 1);
        end else begin
            n_sel   = in_members;
            div_sel = DW'(r_bw);
        end
    end

    // Shared adder: multiply steps add, division steps subtract
    logic [DW:0]      rem2;
    logic [AW-1:0]    alu_a;
    logic [AW-1:0]    alu_b;
    rri_pkg::t_alu_op alu_op;
    logic [AW-1:0]    alu_sum;
    logic             div_neg;

    always_comb begin
        rem2 = {r_rem, r_p[PW-1]};
        if (r_state == S_DIV) begin
            alu_a  = AW'(rem2);
            alu_b  = AW'(r_div);
            alu_op = rri_pkg::ALU_SUB;
        end else begin
            alu_a  = r_acc;
            alu_b  = r_mplier[0] ? r_mcand : '0;
            alu_op = rri_pkg::ALU_ADD;
        end
    end

    assign div_neg = alu_sum[AW-1];

    rri_alu #(
        .W(AW)
    ) u_alu (
        .i_a  (alu_a),
        .i_b  (alu_b),
        .i_op (alu_op),
        .o_sum(alu_sum)
    );

    // Cap the quotient, then raise it to the minimum interval
    logic [TW-1:0] t_capped;
    logic [TW-1:0] t_floor;
    logic          out_sat;

    always_comb begin
        t_capped = (r_p > PW'(rri_pkg::T_CAP)) ? rri_pkg::T_CAP : r_p[TW-1:0];
        t_floor  = (t_capped < TW'(r_min_t)) ? TW'(r_min_t) : t_capped;
        out_sat  = |r_acc[AW-1:RB+OW];
    end

    logic fin_load;
    assign fin_load = (r_state == S_FIN) && (!r_o_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_avg     <= rri_pkg::INIT_AVG;
            r_bw      <= rri_pkg::BW_RESET;
            r_min_cfg <= rri_pkg::MIN_RESET;
            r_o_valid <= 1'b0;
        end else begin
            // Register writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    rri_pkg::CFG_SESSION_BW:   r_bw      <= i_cfg_data;
                    rri_pkg::CFG_MIN_INTERVAL: r_min_cfg <= i_cfg_data[MW-1:0];
                    default: ;
                endcase
            end

            // Drop the result once taken, unless a new one replaces it
            if (fin_load) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_avg    <= avg_new;
                        r_acc    <= '0;
                        r_mcand  <= AW'(n_sel);
                        r_mplier <= MPW'(avg_new);
                        r_k4     <= few_senders;
                        r_div    <= div_sel;
                        r_min_t  <= in_first ? (r_min_cfg >> 1) : r_min_cfg;
                        r_m      <= {1'b0, in_rand} + RAND_HALF;
                        r_cnt    <= '0;
                        r_state  <= S_MULQ;
                    end
                end
                S_MULQ: begin
                    // q = avg * n, one average bit a step
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNTW'(SW - 1)) begin
                        r_acc    <= '0;
                        r_mcand  <= alu_sum;
                        r_mplier <= MPW'(r_k4 ? rri_pkg::K_FOUR : rri_pkg::K_ONE);
                        r_cnt    <= '0;
                        r_state  <= S_MULK;
                    end else begin
                        r_acc    <= alu_sum;
                        r_mcand  <= r_mcand << 1;
                        r_mplier <= r_mplier >> 1;
                    end
                end
                S_MULK: begin
                    // q * k, one scale bit a step
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNTW'(KW - 1)) begin
                        r_p     <= alu_sum[PW-1:0];
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_acc    <= alu_sum;
                        r_mcand  <= r_mcand << 1;
                        r_mplier <= r_mplier >> 1;
                    end
                end
                S_DIV: begin
                    // Restoring division: shift the dividend out, quotient in.
                    // A zero divisor yields all ones, which the cap absorbs.
                    r_rem <= div_neg ? rem2[DW-1:0] : alu_sum[DW-1:0];
                    r_p   <= {r_p[PW-2:0], !div_neg};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNTW'(PW - 1)) begin
                        r_state <= S_CLAMP;
                    end
                end
                S_CLAMP: begin
                    r_acc    <= '0;
                    r_mcand  <= AW'(t_floor);
                    r_mplier <= MPW'(r_m);
                    r_cnt    <= '0;
                    r_state  <= S_DITH;
                end
                S_DITH: begin
                    // t * (rand + half), one dither bit a step
                    r_acc    <= alu_sum;
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    r_cnt    <= r_cnt + 1'b1;
                    if (r_cnt == CNTW'(RB)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // Hold until the output register is free
                    if (fin_load) begin
                        r_o_interval <= out_sat ? '1 : r_acc[RB+OW-1:RB];
                        r_o_avg      <= r_avg;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = ODW'({r_o_avg, r_o_interval});

    `ASSERT_NEXT(a_accept_goes_busy, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready, "request accepted but block still ready")
    `ASSERT_PROP(a_div_count_bound, i_clk, i_rst_n, (r_state == S_DIV) |-> (r_cnt < CNTW'(PW)), "division step count out of range")
    `ASSERT_NEXT(a_fin_waits_stall, i_clk, i_rst_n, (r_state == S_FIN) && r_o_valid && !i_m_tready, (r_state == S_FIN) && r_o_valid, "result overwrote a stalled output")

endmodule

// ===== tb/tb_rtcp_report_interval.sv =====
module tb_rtcp_report_interval;

    localparam int COUNT_W   = rri_pkg::COUNT_WIDTH_DEF;
    localparam int RAND_W    = rri_pkg::RAND_BITS_DEF;
    localparam int OUT_W     = rri_pkg::OUT_W;
    localparam int SIZE_W    = rri_pkg::SIZE_W;
    localparam int BW_W      = rri_pkg::BW_W;
    localparam int MIN_W     = rri_pkg::MIN_W;
    localparam int REQ_W     = (((2 * COUNT_W + 17 + RAND_W) + 7) / 8) * 8;
    localparam int RES_W     = ((OUT_W + SIZE_W + 7) / 8) * 8;
    localparam int LATENCY   = 79 + COUNT_W + RAND_W;
    localparam int HOLD_LEN  = 1500;
    localparam int PHASE_LEN = 215;

    localparam logic [63:0] CAP_T   = 64'(rri_pkg::T_CAP);
    localparam logic [63:0] MAX_OUT = (64'd1 << OUT_W) - 64'd1;

    typedef struct {
        logic [COUNT_W-1:0] members;
        logic [COUNT_W-1:0] senders;
        logic               we_sent;
        logic [SIZE_W-1:0]  report_size;
        logic               first_call;
        logic [RAND_W-1:0]  dither;
    } t_request;

    typedef struct {
        logic [OUT_W-1:0]  interval_us;
        logic [SIZE_W-1:0] avg_size;
    } t_interval;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic             i_cfg_index = rri_pkg::CFG_SESSION_BW;
    logic [BW_W-1:0]  i_cfg_data = '0;
    logic             i_s_tvalid = 1'b0;
    logic             o_s_tready;
    logic [REQ_W-1:0] i_s_tdata = '0;
    logic [0:0]       i_s_tuser = '0;
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    logic [RES_W-1:0] o_m_tdata;

    // Predictor copy of the block's registers and running average
    logic [BW_W-1:0]   bw_reg;
    logic [MIN_W-1:0]  min_reg;
    logic [SIZE_W-1:0] avg_size;

    t_interval pending_intervals[$];
    int        mismatch_count = 0;
    logic      src_idle_en = 1'b1;
    logic      sink_idle_en = 1'b1;
    logic      hold_go = 1'b0;
    int        hold_left = 0;
    int        sink_wait = 0;

    rtcp_report_interval uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Interval for one request; advances the running average as the block does.
    function automatic t_interval predict_interval(input t_request rq);
        logic [63:0] n;
        logic [63:0] k;
        logic [63:0] d;
        logic [63:0] t;
        logic [63:0] floor_t;
        logic [63:0] m;
        logic [63:0] r;
        logic [63:0] avg;
        logic [63:0] sz;
        t_interval   res;
        floor_t = 64'(min_reg);
        n       = 64'(rq.members);
        k       = 64'(rri_pkg::K_ONE);
        d       = 64'(bw_reg);
        sz      = 64'(rq.report_size);
        if (rq.first_call) begin
            floor_t  = floor_t >> 1;
            avg_size = rri_pkg::INIT_AVG;
        end
        // Few senders: they share a quarter, receivers the other three quarters
        if (rq.senders != 0 && (64'(rq.senders) << 2) < 64'(rq.members)) begin
            k = 64'(rri_pkg::K_FOUR);
            if (rq.we_sent) begin
                n = 64'(rq.senders);
            end else begin
                d = 64'd3 * 64'(bw_reg);
                n = 64'(rq.members) - 64'(rq.senders);
            end
        end
        avg = 64'(avg_size);
        if (sz >= avg) begin
            avg = avg + ((sz - avg) >> 4);
        end else begin
            avg = avg - ((avg - sz) >> 4);
        end
        avg_size = avg[SIZE_W-1:0];
        // avg * n * k stays below 2^54, so the quotient is exact in 64 bits
        if (d == 0) begin
            t = CAP_T;
        end else begin
            t = (avg * n * k) / d;
            if (t > CAP_T) t = CAP_T;
        end
        if (t < floor_t) t = floor_t;
        m = 64'(rq.dither) + (64'd1 << (RAND_W - 1));
        r = (t * m) >> RAND_W;
        if (r > MAX_OUT) r = MAX_OUT;
        res.interval_us = r[OUT_W-1:0];
        res.avg_size    = avg[SIZE_W-1:0];
        return res;
    endfunction

    function automatic t_request make_request(input int members, input int senders,
                                              input logic we_sent, input int report_size,
                                              input logic first_call, input int dither);
        t_request rq;
        rq.members     = COUNT_W'(members);
        rq.senders     = COUNT_W'(senders);
        rq.we_sent     = we_sent;
        rq.report_size = SIZE_W'(report_size);
        rq.first_call  = first_call;
        rq.dither      = RAND_W'(dither);
        return rq;
    endfunction

    // Mostly realistic sessions, with a share of full-range counts and sizes.
    function automatic t_request random_request(input logic first_call);
        t_request rq;
        int       pick;
        pick = $urandom_range(3, 0);
        if (pick < 2) begin
            rq.members = COUNT_W'($urandom_range(60, 1));
        end else if (pick == 2) begin
            rq.members = COUNT_W'($urandom_range(2000, 61));
        end else begin
            rq.members = COUNT_W'($urandom_range(65535, 0));
        end
        pick = $urandom_range(9, 0);
        if (pick < 3) begin
            rq.senders = '0;
        end else if (pick < 7 && rq.members >= 5) begin
            rq.senders = COUNT_W'($urandom_range((int'(rq.members) - 1) / 4, 1));
        end else if (pick == 7) begin
            rq.senders = rq.members >> 2;
        end else begin
            rq.senders = COUNT_W'($urandom_range(65535, 0));
        end
        rq.we_sent = 1'($urandom_range(1, 0));
        if ($urandom_range(9, 0) < 7) begin
            rq.report_size = SIZE_W'($urandom_range(400, 40));
        end else begin
            rq.report_size = SIZE_W'($urandom_range(65535, 0));
        end
        rq.first_call = first_call;
        rq.dither     = RAND_W'($urandom_range(32767, 0));
        return rq;
    endfunction

    // Offer one request and return at the edge that accepts it; tvalid stays
    // high so a back-to-back request needs no extra edge.
    task automatic send_request(input t_request rq);
        int gap;
        gap = src_idle_en ? $urandom_range(8, 0) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tdata  <= {rq.dither, rq.report_size, rq.we_sent, rq.senders, rq.members};
        i_s_tuser  <= rq.first_call;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        pending_intervals.push_back(predict_interval(rq));
    endtask

    // Drop tvalid, wait for every outstanding result, then let the pipe settle.
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_intervals.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    // Pulse the write enable for one edge, then hold it low before returning.
    task automatic write_config(input logic index, input logic [BW_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        if (index == rri_pkg::CFG_SESSION_BW) begin
            bw_reg = value;
        end else begin
            min_reg = value[MIN_W-1:0];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_directed_corners();
        // First call with one member and zero senders, size and dither
        send_request(make_request(1, 0, 1'b0, 0, 1'b1, 0));
        // Largest member count, size and dither
        send_request(make_request(65535, 0, 1'b1, 65535, 1'b0, 32767));
        // No members at all: minimum interval takes over
        send_request(make_request(0, 0, 1'b0, 200, 1'b0, 12345));
        // Quarter bandwidth for senders, three quarters for receivers
        send_request(make_request(100, 10, 1'b1, 300, 1'b0, 16384));
        send_request(make_request(100, 10, 1'b0, 300, 1'b0, 100));
        // Around the quarter boundary: full bandwidth unless four times senders is below members
        send_request(make_request(100, 25, 1'b1, 300, 1'b0, 200));
        send_request(make_request(101, 25, 1'b0, 300, 1'b0, 300));
        send_request(make_request(65535, 65535, 1'b1, 0, 1'b0, 32767));
        send_request(make_request(5, 1, 1'b1, 0, 1'b0, 1));
        // Shrinking average: step truncates toward zero
        send_request(make_request(40, 0, 1'b0, 0, 1'b0, 0));
        send_request(make_request(40, 0, 1'b0, 17, 1'b0, 0));
        // First call in mid-stream restarts the average
        send_request(make_request(50, 3, 1'b0, 65535, 1'b1, 32767));
        send_request(make_request(65535, 16383, 1'b0, 65535, 1'b0, 0));
        send_request(make_request(65535, 16384, 1'b1, 65535, 1'b0, 21845));
    endtask

    task automatic test_zero_and_huge();
        drain_results();
        // Zero bandwidth saturates the interval
        write_config(rri_pkg::CFG_SESSION_BW, '0);
        write_config(rri_pkg::CFG_MIN_INTERVAL, BW_W'(60000000));
        send_request(make_request(10, 0, 1'b0, 100, 1'b1, 0));
        send_request(make_request(100, 5, 1'b1, 100, 1'b0, 32767));
        send_request(make_request(100, 5, 1'b0, 100, 1'b0, 9));
        drain_results();
        // Tiny bandwidth and big sessions overflow before dithering
        write_config(rri_pkg::CFG_SESSION_BW, BW_W'(1));
        write_config(rri_pkg::CFG_MIN_INTERVAL, '0);
        send_request(make_request(65535, 0, 1'b0, 65535, 1'b1, 0));
        send_request(make_request(65535, 1000, 1'b0, 65535, 1'b0, 32767));
        send_request(make_request(65535, 1000, 1'b1, 65535, 1'b0, 1));
        send_request(make_request(1, 0, 1'b0, 0, 1'b0, 0));
    endtask

    task automatic test_output_backpressure();
        drain_results();
        write_config(rri_pkg::CFG_SESSION_BW, BW_W'(1000));
        write_config(rri_pkg::CFG_MIN_INTERVAL, BW_W'(5000000));
        src_idle_en = 1'b0;
        // Hold off the sink long enough for the block to back up onto its input
        hold_go <= 1'b1;
        @(posedge i_clk);
        hold_go <= 1'b0;
        send_request(random_request(1'b1));
        repeat (11) send_request(random_request(1'b0));
        src_idle_en = 1'b1;
    endtask

    task automatic test_random_sessions();
        for (int ph = 0; ph < 6; ph++) begin
            drain_results();
            case (ph)
                0: begin
                    write_config(rri_pkg::CFG_SESSION_BW, BW_W'(1000));
                    write_config(rri_pkg::CFG_MIN_INTERVAL, BW_W'(5000000));
                end
                1: begin
                    write_config(rri_pkg::CFG_SESSION_BW, BW_W'(1));
                    write_config(rri_pkg::CFG_MIN_INTERVAL, '0);
                end
                2: begin
                    // Upper data bits of the minimum interval are dropped
                    write_config(rri_pkg::CFG_SESSION_BW, '1);
                    write_config(rri_pkg::CFG_MIN_INTERVAL, '1);
                end
                3: begin
                    write_config(rri_pkg::CFG_SESSION_BW,
                                 BW_W'($urandom_range(100000, 100)));
                    write_config(rri_pkg::CFG_MIN_INTERVAL,
                                 BW_W'($urandom_range(60000000, 0)));
                end
                4: begin
                    write_config(rri_pkg::CFG_SESSION_BW,
                                 BW_W'($urandom_range(1073741823, 1)));
                    write_config(rri_pkg::CFG_MIN_INTERVAL,
                                 BW_W'($urandom_range(67108863, 0)));
                end
                default: begin
                    write_config(rri_pkg::CFG_SESSION_BW,
                                 BW_W'($urandom_range(8000, 1000)));
                    write_config(rri_pkg::CFG_MIN_INTERVAL, BW_W'(2500000));
                end
            endcase
            // One phase runs flat out on both sides
            src_idle_en = (ph != 2);
            sink_idle_en <= (ph != 2);
            send_request(random_request(1'b1));
            for (int i = 1; i < PHASE_LEN; i++) begin
                send_request(random_request($urandom_range(19, 0) == 0));
            end
        end
    endtask

    // Result sink: check every accepted result, stall at random once a
    // result shows up, and hold off entirely on request.
    always @(posedge i_clk) begin : result_sink
        int        stall;
        t_interval exp_res;
        t_interval got;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            sink_wait  <= 0;
            hold_left  <= 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got.interval_us = o_m_tdata[OUT_W-1:0];
                got.avg_size    = o_m_tdata[OUT_W+SIZE_W-1:OUT_W];
                if (pending_intervals.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("unexpected result: interval %0d avg %0d",
                                 got.interval_us, got.avg_size);
                    end
                end else begin
                    exp_res = pending_intervals.pop_front();
                    if (got.interval_us !== exp_res.interval_us ||
                        got.avg_size !== exp_res.avg_size) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("result mismatch: interval exp %0d got %0d, avg exp %0d got %0d",
                                     exp_res.interval_us, got.interval_us,
                                     exp_res.avg_size, got.avg_size);
                        end
                    end
                end
            end
            if (hold_go) begin
                hold_left  <= HOLD_LEN;
                i_m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left  <= hold_left - 1;
                i_m_tready <= (hold_left == 1);
            end else if (o_m_tvalid && i_m_tready) begin
                stall = sink_idle_en ? $urandom_range(8, 0) : 0;
                sink_wait  <= stall;
                i_m_tready <= (stall == 0);
            end else if (sink_wait > 0) begin
                // Count the stall only while a result is waiting
                if (o_m_tvalid) begin
                    sink_wait  <= sink_wait - 1;
                    i_m_tready <= (sink_wait == 1);
                end
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    initial begin
        bw_reg   = rri_pkg::BW_RESET;
        min_reg  = rri_pkg::MIN_RESET;
        avg_size = rri_pkg::INIT_AVG;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_corners();
        test_zero_and_huge();
        test_output_backpressure();
        test_random_sessions();
        drain_results();
        if (mismatch_count == 0 && pending_intervals.size() == 0) begin
            $display("tb_rtcp_report_interval passed");
        end else begin
            $display("tb_rtcp_report_interval failed");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("tb_rtcp_report_interval failed");
        $finish;
    end

endmodule
